>>> hw/rtl/bfs_pkg.sv
package bfs_pkg;

  // Node identifiers are six bits wide, so the node table holds 64 entries.
  localparam int NodeW    = 6;
  localparam int HopW     = 7;
  localparam int NodeCntW = 7;
  localparam int MaxNodes = 1 << NodeW;

  localparam int MaxEdgesDefault = 256;
  localparam int EdgeW           = 2 * NodeW;

  localparam logic [NodeCntW-1:0] NodeCountReset  = NodeCntW'(MaxNodes);
  localparam logic [NodeW-1:0]    SourceNodeReset = '0;

  // Unvisited nodes report all ones, which reads as -1.
  localparam logic [HopW-1:0] Unvisited = '1;

  localparam int CfgIdxW   = 1;
  localparam int CfgWdataW = NodeCntW;

  localparam logic [CfgIdxW-1:0] CfgNodeCount  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgSourceNode = 1'd1;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [HopW-1:0]  hops;
  } queue_entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StInit,
    StDeq,
    StLoad,
    StScan,
    StOut
  } bfs_state_e;

endpackage

>>> hw/rtl/bfs_ram.sv
module bfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/bfs_unit_distance_shortest_path.sv
// Breadth-first shortest path search with unit edge weights.
// Edges enter on the command channel: an item transfers at a clock edge with
// start high and busy low. An item with edge_valid_i set stores one
// undirected edge; one edge loads per cycle while busy stays low. Edges
// beyond MAX_EDGES are dropped. An item with last_edge_i set raises busy and
// starts the search from the configured source node over the stored edges.
// The search sets up, then for every node it reaches does one queue read
// and one edge scan of the E stored edges through the edge memory's single
// read port, and the search ends when it finds the queue empty. Then the
// block reads the distance memory once per node: N results, one per cycle,
// in node order, each shown for one cycle with result_valid_o high and the
// last one flagged by last_node_o. busy falls in the cycle that shows the
// final result, and the edge store is empty again for the next graph.
// The receiver cannot stall; results are never held back.
// Write node_count and source_node on the configuration port only while idle; the block does not enforce this.
// Reset clears the edge count and loads node_count = 64 and source_node = 0.
// The distance table is marked unvisited at the start of every search.
module bfs_unit_distance_shortest_path #(
  parameter int MAX_EDGES = bfs_pkg::MaxEdgesDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                start,
  output logic                                busy,
  input  logic [bfs_pkg::NodeW-1:0]           node_a_i,
  input  logic [bfs_pkg::NodeW-1:0]           node_b_i,
  input  logic                                edge_valid_i,
  input  logic                                last_edge_i,

  output logic                                result_valid_o,
  output logic [bfs_pkg::NodeW-1:0]           node_index_o,
  output logic signed [bfs_pkg::HopW-1:0]     distance_o,
  output logic                                last_node_o,

  input  logic                                cfg_we_i,
  input  logic [bfs_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [bfs_pkg::CfgWdataW-1:0]       cfg_wdata_i
);

  localparam int NodeW = bfs_pkg::NodeW;
  localparam int HopW  = bfs_pkg::HopW;
  localparam int CntW  = bfs_pkg::NodeCntW;
  localparam int EdgeW = bfs_pkg::EdgeW;
  localparam int EaW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EtW   = $clog2(MAX_EDGES + 1);
  localparam int QeW   = $bits(bfs_pkg::queue_entry_t);

  // Configuration registers.
  logic [CntW-1:0]  node_count_q;
  logic [NodeW-1:0] source_node_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= bfs_pkg::NodeCountReset;
      source_node_q <= bfs_pkg::SourceNodeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfs_pkg::CfgNodeCount:  node_count_q  <= cfg_wdata_i;
        bfs_pkg::CfgSourceNode: source_node_q <= cfg_wdata_i[NodeW-1:0];
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] active_n;

  always_comb begin
    if (node_count_q == '0) begin
      active_n = CntW'(1);
    end else if (node_count_q > CntW'(bfs_pkg::MaxNodes)) begin
      active_n = CntW'(bfs_pkg::MaxNodes);
    end else begin
      active_n = node_count_q;
    end
  end

  // State.
  bfs_pkg::bfs_state_e state_q, state_d;

  logic [EtW-1:0]                edge_total_q, edge_total_d;
  logic [EtW-1:0]                edge_idx_q, edge_idx_d;
  logic [CntW-1:0]               head_q, head_d;
  logic [CntW-1:0]               tail_q, tail_d;
  logic [CntW-1:0]               out_cnt_q, out_cnt_d;
  logic [bfs_pkg::MaxNodes-1:0]  visited_q, visited_d;
  logic                          out_pend_q, out_pend_d;
  logic [NodeW-1:0]              cur_q, cur_d;
  logic [HopW-1:0]               next_hops_q, next_hops_d;
  logic [NodeW-1:0]              out_idx_q, out_idx_d;
  logic                          out_vis_q, out_vis_d;
  logic                          out_last_q, out_last_d;

  // Memories.
  logic                          edge_we;
  logic [EaW-1:0]                edge_raddr;
  logic [EdgeW-1:0]              edge_rdata;
  logic                          visit_en;
  logic [NodeW-1:0]              visit_node;
  logic [HopW-1:0]               visit_hops;
  logic [HopW-1:0]               hop_rdata;
  bfs_pkg::queue_entry_t         queue_wdata, queue_rdata;
  logic [QeW-1:0]                queue_rdata_raw;
  logic [NodeW-1:0]              queue_waddr;

  logic accept;
  assign busy   = (state_q != bfs_pkg::StIdle);
  assign accept = start && !busy;

  assign edge_we    = accept && edge_valid_i && (edge_total_q < EtW'(MAX_EDGES));
  assign edge_raddr = (state_q == bfs_pkg::StLoad) ? '0 : edge_idx_q[EaW-1:0];

  bfs_ram #(
    .Width (EdgeW),
    .Depth (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_total_q[EaW-1:0]),
    .wdata_i ({node_a_i, node_b_i}),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  bfs_ram #(
    .Width (HopW),
    .Depth (bfs_pkg::MaxNodes)
  ) u_hop_ram (
    .clk_i   (clk_i),
    .we_i    (visit_en),
    .waddr_i (visit_node),
    .wdata_i (visit_hops),
    .raddr_i (out_cnt_q[NodeW-1:0]),
    .rdata_o (hop_rdata)
  );

  assign queue_wdata.node = visit_node;
  assign queue_wdata.hops = visit_hops;
  assign queue_rdata      = bfs_pkg::queue_entry_t'(queue_rdata_raw);

  // The source always takes the first queue slot, whatever the tail holds
  // from the previous search.
  assign queue_waddr = (state_q == bfs_pkg::StInit) ? '0 : tail_q[NodeW-1:0];

  bfs_ram #(
    .Width (QeW),
    .Depth (bfs_pkg::MaxNodes)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (visit_en),
    .waddr_i (queue_waddr),
    .wdata_i (queue_wdata),
    .raddr_i (head_q[NodeW-1:0]),
    .rdata_o (queue_rdata_raw)
  );

  // Edge scan: the edge read in the previous cycle is checked against the
  // node being expanded. Only one endpoint can lead elsewhere, so one visit
  // per edge suffices.
  logic [NodeW-1:0] scan_a, scan_b, scan_tgt;
  logic             scan_in_range, scan_hit_a, scan_hit;
  logic             src_ok, queue_empty, scan_more, out_done, queue_room;

  assign scan_a        = edge_rdata[EdgeW-1:NodeW];
  assign scan_b        = edge_rdata[NodeW-1:0];
  assign scan_in_range = ({1'b0, scan_a} < active_n) && ({1'b0, scan_b} < active_n);
  assign scan_hit_a    = (scan_a == cur_q);
  assign scan_hit      = scan_in_range && (scan_hit_a || (scan_b == cur_q));
  assign scan_tgt      = scan_hit_a ? scan_b : scan_a;
  assign queue_room    = (tail_q < CntW'(bfs_pkg::MaxNodes));

  assign src_ok      = ({1'b0, source_node_q} < active_n);
  assign queue_empty = (head_q == tail_q);
  assign scan_more   = (edge_idx_q < edge_total_q);
  assign out_done    = ((out_cnt_q + CntW'(1)) == active_n);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfs_pkg::StIdle: if (accept && last_edge_i) state_d = bfs_pkg::StInit;
      bfs_pkg::StInit: state_d = src_ok ? bfs_pkg::StDeq : bfs_pkg::StOut;
      bfs_pkg::StDeq:  state_d = queue_empty ? bfs_pkg::StOut : bfs_pkg::StLoad;
      bfs_pkg::StLoad: state_d = (edge_total_q == '0) ? bfs_pkg::StDeq : bfs_pkg::StScan;
      bfs_pkg::StScan: if (!scan_more) state_d = bfs_pkg::StDeq;
      bfs_pkg::StOut:  if (out_done) state_d = bfs_pkg::StIdle;
      default:         state_d = bfs_pkg::StIdle;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    edge_total_d = edge_total_q;
    edge_idx_d   = edge_idx_q;
    head_d       = head_q;
    tail_d       = tail_q;
    out_cnt_d    = out_cnt_q;
    visited_d    = visited_q;
    cur_d        = cur_q;
    next_hops_d  = next_hops_q;
    out_pend_d   = 1'b0;
    out_idx_d    = out_idx_q;
    out_vis_d    = out_vis_q;
    out_last_d   = out_last_q;
    visit_en     = 1'b0;
    visit_node   = scan_tgt;
    visit_hops   = next_hops_q;

    unique case (state_q)
      bfs_pkg::StIdle: begin
        if (edge_we) begin
          edge_total_d = edge_total_q + EtW'(1);
        end
      end
      bfs_pkg::StInit: begin
        head_d     = '0;
        visited_d  = '0;
        visit_node = source_node_q;
        visit_hops = '0;
        if (src_ok) begin
          visit_en              = 1'b1;
          visited_d[visit_node] = 1'b1;
          tail_d                = CntW'(1);
        end else begin
          tail_d = '0;
        end
        out_cnt_d = '0;
      end
      bfs_pkg::StDeq: begin
        if (!queue_empty) begin
          head_d = head_q + CntW'(1);
        end
        out_cnt_d = '0;
      end
      bfs_pkg::StLoad: begin
        cur_d       = queue_rdata.node;
        next_hops_d = queue_rdata.hops + HopW'(1);
        edge_idx_d  = EtW'(1);
      end
      bfs_pkg::StScan: begin
        if (scan_hit && !visited_q[scan_tgt] && queue_room) begin
          visit_en            = 1'b1;
          visited_d[scan_tgt] = 1'b1;
          tail_d              = tail_q + CntW'(1);
        end
        if (scan_more) begin
          edge_idx_d = edge_idx_q + EtW'(1);
        end
      end
      bfs_pkg::StOut: begin
        out_pend_d = 1'b1;
        out_idx_d  = out_cnt_q[NodeW-1:0];
        out_vis_d  = visited_q[out_cnt_q[NodeW-1:0]];
        out_last_d = out_done;
        out_cnt_d  = out_cnt_q + CntW'(1);
        if (out_done) begin
          edge_total_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bfs_pkg::StIdle;
      edge_total_q <= '0;
      edge_idx_q   <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      out_cnt_q    <= '0;
      visited_q    <= '0;
      out_pend_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      edge_total_q <= edge_total_d;
      edge_idx_q   <= edge_idx_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      out_cnt_q    <= out_cnt_d;
      visited_q    <= visited_d;
      out_pend_q   <= out_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    next_hops_q <= next_hops_d;
    out_idx_q   <= out_idx_d;
    out_vis_q   <= out_vis_d;
    out_last_q  <= out_last_d;
  end

  // The distance memory returns the entry read in the previous cycle.
  assign result_valid_o = out_pend_q;
  assign node_index_o   = out_idx_q;
  assign distance_o     = out_vis_q ? signed'(hop_rdata) : signed'(bfs_pkg::Unvisited);
  assign last_node_o    = out_last_q;

endmodule

>>> verif/bfs_unit_distance_shortest_path_tb.sv
`timescale 1ns / 1ps

module bfs_unit_distance_shortest_path_tb;
  import bfs_pkg::*;

  localparam int RandItemTarget = 350;
  localparam int SettleCycles   = 4;
  localparam int EndDrainCycles = 32;
  localparam int NumDirRows     = 17;

  typedef struct packed {
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
    logic             edge_valid;
    logic             last_edge;
  } edge_item_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [HopW-1:0]  hops;
    logic             last;
  } node_dist_t;

  // A row may carry one distance that is known by inspection of the graph.
  typedef struct packed {
    logic                 cfg;
    logic [NodeCntW-1:0]  nodes;
    logic [CfgWdataW-1:0] src;
    edge_item_t           item;
    logic                 pin;
    logic [NodeW-1:0]     pin_node;
    logic [HopW-1:0]      pin_dist;
  } dir_row_t;

  typedef enum int {
    GraphSparse,
    GraphChain,
    GraphNoise,
    GraphOverflow
  } graph_kind_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [NodeW-1:0]            node_a_i;
  logic [NodeW-1:0]            node_b_i;
  logic                        edge_valid_i;
  logic                        last_edge_i;
  logic                        result_valid_o;
  logic [NodeW-1:0]            node_index_o;
  logic signed [HopW-1:0]      distance_o;
  logic                        last_node_o;
  logic                        cfg_we_i;
  logic [CfgIdxW-1:0]          cfg_idx_i;
  logic [CfgWdataW-1:0]        cfg_wdata_i;

  // Shadow copy of the block's edge store, registers and last search.
  logic [EdgeW-1:0]    edge_copy [MaxEdgesDefault];
  int unsigned         edge_copy_cnt = 0;
  logic [NodeCntW-1:0] cfg_node_count = NodeCountReset;
  logic [NodeW-1:0]    cfg_source = SourceNodeReset;
  logic [HopW-1:0]     search_hops [MaxNodes];
  node_dist_t          dist_expected_q [$];

  dir_row_t    dir_tbl [NumDirRows];
  edge_item_t  graph_q [$];
  int          burst_left = 0;
  int          errors = 0;
  int          items_sent = 0;
  int          searches = 0;
  int          results_checked = 0;
  int          config_writes = 0;

  bfs_unit_distance_shortest_path u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .edge_valid_i  (edge_valid_i),
    .last_edge_i   (last_edge_i),
    .result_valid_o(result_valid_o),
    .node_index_o  (node_index_o),
    .distance_o    (distance_o),
    .last_node_o   (last_node_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #60ms;
    $display("bfs_unit_distance_shortest_path: mismatch");
    $finish;
  end

  // Zero nodes behaves as one node, and counts above the table size saturate.
  function automatic int unsigned eff_nodes(input logic [NodeCntW-1:0] nodes);
    if (nodes == 0) return 1;
    if (nodes > MaxNodes) return MaxNodes;
    return 32'(nodes);
  endfunction

  function automatic dir_row_t dir_row(input int cfg, input int nodes, input int src,
                                       input int a, input int b, input int ev,
                                       input int lst, input int pin, input int pn,
                                       input int pd);
    dir_row_t r;
    r.cfg             = 1'(cfg);
    r.nodes           = NodeCntW'(nodes);
    r.src             = CfgWdataW'(src);
    r.item.node_a     = NodeW'(a);
    r.item.node_b     = NodeW'(b);
    r.item.edge_valid = 1'(ev);
    r.item.last_edge  = 1'(lst);
    r.pin             = 1'(pin);
    r.pin_node        = NodeW'(pn);
    r.pin_dist        = HopW'(pd);
    return r;
  endfunction

  function automatic logic [NodeW-1:0] pick_node(input int unsigned n);
    if ($urandom_range(0, 9) == 0) return NodeW'($urandom_range(0, MaxNodes - 1));
    return NodeW'($urandom_range(0, n - 1));
  endfunction

  // Stores the edge of an accepted item and, on the final item of a graph,
  // runs the search and queues one distance per node in use.
  task automatic predict_distances(input edge_item_t it);
    int unsigned     n;
    int unsigned     head;
    int unsigned     tail;
    int unsigned     cur;
    int unsigned     ea;
    int unsigned     eb;
    int unsigned     order [MaxNodes];
    logic [HopW-1:0] step_hops;
    node_dist_t      entry;
    if (it.edge_valid && edge_copy_cnt < MaxEdgesDefault) begin
      edge_copy[edge_copy_cnt] = {it.node_a, it.node_b};
      edge_copy_cnt++;
    end
    if (it.last_edge) begin
      n = eff_nodes(cfg_node_count);
      for (int k = 0; k < MaxNodes; k++) search_hops[k] = Unvisited;
      head = 0;
      tail = 0;
      if (cfg_source < n) begin
        search_hops[cfg_source] = '0;
        order[0] = cfg_source;
        tail = 1;
      end
      while (head < tail) begin
        cur = order[head];
        head++;
        step_hops = search_hops[cur] + 1'b1;
        for (int e = 0; e < edge_copy_cnt; e++) begin
          ea = edge_copy[e][EdgeW-1:NodeW];
          eb = edge_copy[e][NodeW-1:0];
          if (ea < n && eb < n) begin
            if (ea == cur && search_hops[eb] == Unvisited) begin
              search_hops[eb] = step_hops;
              order[tail] = eb;
              tail++;
            end
            if (eb == cur && search_hops[ea] == Unvisited) begin
              search_hops[ea] = step_hops;
              order[tail] = ea;
              tail++;
            end
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        entry.node = NodeW'(k);
        entry.hops = search_hops[k];
        entry.last = (k == n - 1);
        dist_expected_q = {dist_expected_q, entry};
      end
      edge_copy_cnt = 0;
      searches++;
    end
  endtask

  // The sender works in bursts; between bursts start is sometimes dropped.
  task automatic drive_item(input edge_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
    end
    start        <= 1'b1;
    node_a_i     <= it.node_a;
    node_b_i     <= it.node_b;
    edge_valid_i <= it.edge_valid;
    last_edge_i  <= it.last_edge;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_distances(it);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_drained(input int settle);
    start <= 1'b0;
    burst_left = 0;
    while (dist_expected_q.size() != 0 || busy) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Both registers go in back to back with the write enable held high.
  task automatic set_config(input logic [NodeCntW-1:0] nodes,
                            input logic [CfgWdataW-1:0] src);
    wait_drained(SettleCycles);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgNodeCount;
    cfg_wdata_i <= nodes;
    @(posedge clk_i);
    cfg_node_count = nodes;
    cfg_idx_i   <= CfgSourceNode;
    cfg_wdata_i <= src;
    @(posedge clk_i);
    cfg_source = src[NodeW-1:0];
    cfg_we_i <= 1'b0;
    config_writes++;
  endtask

  always @(posedge clk_i) begin : result_check
    node_dist_t want;
    if (rst_ni && result_valid_o) begin
      if (dist_expected_q.size() == 0) begin
        $error("unexpected result: node_index %0d distance %0d last_node %0b",
               node_index_o, distance_o, last_node_o);
        errors++;
      end else begin
        want = dist_expected_q.pop_front();
        results_checked++;
        if (node_index_o !== want.node) begin
          $error("node_index: expected %0d, got %0d", want.node, node_index_o);
          errors++;
        end
        if (distance_o !== want.hops) begin
          $error("distance of node %0d: expected %0d, got %0d",
                 want.node, $signed(want.hops), distance_o);
          errors++;
        end
        if (last_node_o !== want.last) begin
          $error("last_node of node %0d: expected %0b, got %0b",
                 want.node, want.last, last_node_o);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned  n;
    int unsigned  m;
    int unsigned  rand_items;
    int           graphs;
    int           j;
    int           tmp;
    int           perm [MaxNodes];
    graph_kind_e  kind;
    logic [NodeCntW-1:0]  nodes;
    logic [CfgWdataW-1:0] src;
    edge_item_t   it;

    rst_ni       <= 1'b0;
    start        <= 1'b0;
    node_a_i     <= '0;
    node_b_i     <= '0;
    edge_valid_i <= 1'b0;
    last_edge_i  <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CfgNodeCount;
    cfg_wdata_i  <= '0;

    // Defaults after reset: node 0 is the source and nothing else is reached.
    dir_tbl[0]  = dir_row(0, 64, 0, 0, 0, 0, 1, 1, 63, -1);
    dir_tbl[1]  = dir_row(1, 2, 0, 0, 1, 1, 1, 1, 1, 1);
    dir_tbl[2]  = dir_row(1, 64, 63, 63, 62, 1, 0, 0, 0, 0);
    dir_tbl[3]  = dir_row(0, 0, 0, 0, 62, 1, 1, 1, 0, 2);
    // An endpoint beyond the node count drops the whole edge.
    dir_tbl[4]  = dir_row(1, 4, 0, 0, 63, 1, 0, 0, 0, 0);
    dir_tbl[5]  = dir_row(0, 0, 0, 1, 0, 1, 1, 1, 1, 1);
    // Self loops and repeated edges leave the distances alone.
    dir_tbl[6]  = dir_row(1, 3, 2, 2, 2, 1, 0, 0, 0, 0);
    dir_tbl[7]  = dir_row(0, 0, 0, 2, 1, 1, 0, 0, 0, 0);
    dir_tbl[8]  = dir_row(0, 0, 0, 1, 2, 1, 0, 0, 0, 0);
    dir_tbl[9]  = dir_row(0, 0, 0, 1, 0, 1, 1, 1, 0, 2);
    // A source at or beyond the node count reaches nothing; zero and too large node counts are clamped.
    dir_tbl[10] = dir_row(1, 5, 5, 5, 0, 1, 0, 0, 0, 0);
    dir_tbl[11] = dir_row(0, 0, 0, 0, 1, 1, 1, 1, 1, -1);
    dir_tbl[12] = dir_row(1, 0, 0, 0, 0, 0, 1, 1, 0, 0);
    dir_tbl[13] = dir_row(1, 127, 63, 31, 32, 0, 1, 1, 63, 0);
    // Endpoints on an item without edge_valid are not stored.
    dir_tbl[14] = dir_row(1, 3, 0, 0, 1, 0, 0, 0, 0, 0);
    dir_tbl[15] = dir_row(0, 0, 0, 0, 2, 0, 1, 1, 1, -1);
    dir_tbl[16] = dir_row(1, 64, 40, 40, 21, 1, 1, 1, 21, 1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].cfg) set_config(dir_tbl[i].nodes, dir_tbl[i].src);
      drive_item(dir_tbl[i].item);
      if (dir_tbl[i].pin && search_hops[dir_tbl[i].pin_node] !== dir_tbl[i].pin_dist) begin
        $error("distance of node %0d: expected %0d, got %0d", dir_tbl[i].pin_node,
               $signed(dir_tbl[i].pin_dist), $signed(search_hops[dir_tbl[i].pin_node]));
        errors++;
      end
    end

    rand_items = 0;
    graphs = 0;
    while (rand_items < RandItemTarget) begin
      case ($urandom_range(0, 15))
        0:       kind = GraphChain;
        1, 2:    kind = GraphNoise;
        default: kind = GraphSparse;
      endcase
      if (graphs == 1) kind = GraphChain;
      if (graphs == 2) kind = GraphOverflow;
      graph_q.delete();

      if (kind == GraphChain) begin
        nodes = NodeCntW'($urandom_range(33, 64));
        n = eff_nodes(nodes);
        for (int k = 0; k < n; k++) perm[k] = k;
        for (int k = n - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = perm[k];
          perm[k] = perm[j];
          perm[j] = tmp;
        end
        // Starting at one end of the path gives the longest distances.
        set_config(nodes, {1'($urandom_range(0, 1)), NodeW'(perm[0])});
        for (int k = 0; k + 1 < n; k++) begin
          it.edge_valid = 1'b1;
          it.last_edge  = (k + 2 == n);
          if ($urandom_range(0, 1)) begin
            it.node_a = NodeW'(perm[k]);
            it.node_b = NodeW'(perm[k + 1]);
          end else begin
            it.node_a = NodeW'(perm[k + 1]);
            it.node_b = NodeW'(perm[k]);
          end
          graph_q = {graph_q, it};
        end
      end else begin
        if (kind == GraphOverflow) begin
          nodes = NodeCntW'($urandom_range(4, 10));
        end else if (graphs == 0 || $urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 9))
            0:       nodes = '0;
            1:       nodes = NodeCntW'(1);
            2:       nodes = '1;
            3:       nodes = NodeCntW'(MaxNodes);
            4:       nodes = NodeCntW'($urandom_range(MaxNodes + 1, 127));
            5, 6:    nodes = NodeCntW'($urandom_range(2, 12));
            default: nodes = NodeCntW'($urandom_range(1, MaxNodes));
          endcase
        end else begin
          nodes = cfg_node_count;
        end
        n = eff_nodes(nodes);
        if (kind == GraphOverflow || nodes != cfg_node_count || graphs == 0) begin
          if ($urandom_range(0, 7) == 0) src[NodeW-1:0] = NodeW'($urandom_range(0, 63));
          else src[NodeW-1:0] = NodeW'($urandom_range(0, n - 1));
          src[CfgWdataW-1] = 1'($urandom_range(0, 1));
          set_config(nodes, src);
        end
        case (kind)
          GraphOverflow: m = MaxEdgesDefault + $urandom_range(1, 10);
          GraphNoise:    m = $urandom_range(1, 10);
          default:       m = $urandom_range(0, 20);
        endcase
        for (int k = 0; k < m; k++) begin
          it.last_edge = 1'b0;
          if (kind == GraphNoise) begin
            it.node_a     = NodeW'($urandom_range(0, 63));
            it.node_b     = NodeW'($urandom_range(0, 63));
            it.edge_valid = ($urandom_range(0, 3) == 0);
          end else if (kind == GraphOverflow) begin
            it.node_a     = NodeW'($urandom_range(0, n - 1));
            it.node_b     = NodeW'($urandom_range(0, n - 1));
            it.edge_valid = 1'b1;
          end else begin
            it.node_a     = pick_node(n);
            it.node_b     = pick_node(n);
            it.edge_valid = ($urandom_range(0, 11) != 0);
          end
          graph_q = {graph_q, it};
        end
        it.node_a     = pick_node(n);
        it.node_b     = pick_node(n);
        it.edge_valid = 1'($urandom_range(0, 1));
        it.last_edge  = 1'b1;
        graph_q = {graph_q, it};
      end

      foreach (graph_q[k]) begin
        drive_item(graph_q[k]);
        rand_items++;
      end
      graphs++;
    end

    wait_drained(EndDrainCycles);
    $display("%0d items in %0d graphs, %0d distances checked, %0d register settings",
             items_sent, searches, results_checked, config_writes);
    $display("node counts from zero to 127, sources out of range, a full edge store");
    if (errors == 0) begin
      $display("bfs_unit_distance_shortest_path: match");
    end else begin
      $display("bfs_unit_distance_shortest_path: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/bfs_pkg.sv
hw/rtl/bfs_ram.sv
hw/rtl/bfs_unit_distance_shortest_path.sv
verif/bfs_unit_distance_shortest_path_tb.sv
